// ----- hdl/tsch_pkg.sv -----
`timescale 1ns / 1ps
package tsch_pkg;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_SCHED_AT = 3'd1,
        OP_SCHED_IN = 3'd2,
        OP_SCHED_PD = 3'd3,
        OP_CANCEL   = 3'd4,
        OP_PAUSE    = 3'd5
    } op_t;

    localparam logic [1:0] KIND_SCHED  = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RESCHED,
        CMD_DROP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [63:0] deadline;
        logic [63:0] period;
        logic        repeats;
        logic [31:0] handle;
        logic [63:0] order;
        logic [31:0] fires;
    } cell_cmd_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] deadline;
        logic [63:0] order;
    } cand_t;

    typedef struct packed {
        logic        valid;
        logic        repeats;
        logic [31:0] handle;
        logic [31:0] fires;
        logic [63:0] period;
    } cell_stat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] handle;
        logic [63:0] deadline;
        logic [63:0] fired;
        logic [63:0] late;
        logic [31:0] count;
        logic        found;
        logic        last;
    } result_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

// ----- hdl/timed_event_scheduler.sv -----
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                               | tuser | tlast
// s       | in  | time_value, period_value, handle_in, pause_flag  | op    | -
// m       | out | handle_out, deadline_out, fired_time, lateness,  | kind  | last
//         |     | fires, found                                     |       |
// Pause is taken while idle and gives no output beat. Schedule and cancel are taken into a
// pending register, then moved to the output register once that register is free.
// A tick rescans all slots for each fired event and once more for the final search:
// the earliest due event ripples down the row of slot cells one cell a cycle.
// Reset (rst_n low) empties all slots, clears the clock and sets both counters to one.
// A stalled m side holds the engine before each further beat; s is taken only when idle.
module timed_event_scheduler
    import tsch_pkg::*;
#(
    parameter int EVENT_SLOTS        = 16,
    parameter int MAX_FIRES_PER_TICK = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [167:0]  s_tdata,   // time_value, period_value, handle_in, pause_flag
    input  logic [2:0]    s_tuser,   // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [263:0]  m_tdata,   // handle_out, deadline_out, fired_time, lateness,
                                     // fires, found
    output logic [1:0]    m_tuser,   // kind
    output logic          m_tlast
);

    localparam int IW = $clog2(EVENT_SLOTS);
    localparam int CW = $clog2(EVENT_SLOTS + 1);
    localparam int NW = $clog2(MAX_FIRES_PER_TICK + 1);

    state_t        state_reg, state_next;
    logic [63:0]   now_reg, now_next;
    logic          paused_reg, paused_next;
    logic [31:0]   hctr_reg, hctr_next;
    logic [63:0]   octr_reg, octr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] nfire_reg, nfire_next;
    result_t       pend_reg, pend_next;
    logic          pend_v_reg, pend_v_next;
    result_t       out_reg, out_next;
    logic          out_v_reg, out_v_next;

    cell_cmd_t              cmd;
    logic [EVENT_SLOTS-1:0] sel;
    cand_t                  cand_w [EVENT_SLOTS+1];
    logic [IW-1:0]          idx_w  [EVENT_SLOTS+1];
    cell_stat_t             stat_w [EVENT_SLOTS];

    logic [63:0]   tv, pv;
    logic [31:0]   hin;
    logic          pflag;
    logic          free_hit, match_hit;
    logic [IW-1:0] free_idx, match_idx;
    cand_t         best;
    logic [IW-1:0] best_idx;
    cell_stat_t    bstat;
    logic [31:0]   cnt1;
    logic [31:0]   hinc;

    assign tv    = s_tdata[63:0];
    assign pv    = s_tdata[127:64];
    assign hin   = s_tdata[159:128];
    assign pflag = s_tdata[160];

    assign cand_w[0] = '0;
    assign idx_w[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < EVENT_SLOTS; g++)
        begin : g_cell
            tsch_cell #(.IW(IW), .IDX(g)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .sel      (sel[g]),
                .cmd      (cmd),
                .now      (now_reg),
                .cand_in  (cand_w[g]),
                .idx_in   (idx_w[g]),
                .cand_out (cand_w[g+1]),
                .idx_out  (idx_w[g+1]),
                .stat     (stat_w[g])
            );
        end
    endgenerate

    always_comb
    begin
        free_hit  = 1'b0;
        free_idx  = '0;
        match_hit = 1'b0;
        match_idx = '0;
        for (int i = EVENT_SLOTS - 1; i >= 0; i--)
        begin
            if (!stat_w[i].valid)
            begin
                free_hit = 1'b1;
                free_idx = IW'(i);
            end
            if (stat_w[i].valid && (stat_w[i].handle == hin))
            begin
                match_hit = 1'b1;
                match_idx = IW'(i);
            end
        end
    end

    assign best     = cand_w[EVENT_SLOTS];
    assign best_idx = idx_w[EVENT_SLOTS];
    assign bstat    = stat_w[best_idx];
    assign cnt1     = bstat.fires + 32'd1;
    assign hinc     = (hctr_reg == {32{1'b1}}) ? 32'd1 : hctr_reg + 32'd1;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        logic        hit;
        logic        rej;
        logic [63:0] dl;
        state_next  = state_reg;
        now_next    = now_reg;
        paused_next = paused_reg;
        hctr_next   = hctr_reg;
        octr_next   = octr_reg;
        cnt_next    = cnt_reg;
        nfire_next  = nfire_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        out_next    = out_reg;
        out_v_next  = out_v_reg;
        cmd         = '0;
        cmd.kind    = CMD_NONE;
        sel         = '0;
        hit         = 1'b0;
        rej         = 1'b0;
        dl          = tv;

        if (out_v_reg && m_tready)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pend_next = '0;
                    case (s_tuser)
                        OP_TICK:
                        begin
                            if (!paused_reg)
                            begin
                                now_next    = sat_add(now_reg, tv);
                                cnt_next    = '0;
                                nfire_next  = '0;
                                pend_v_next = 1'b0;
                                state_next  = ST_SCAN;
                            end
                        end
                        OP_SCHED_AT, OP_SCHED_IN, OP_SCHED_PD:
                        begin
                            if (s_tuser == OP_SCHED_IN)
                            begin
                                dl = sat_add(now_reg, tv);
                            end
                            rej = !free_hit || ((s_tuser == OP_SCHED_PD) && (pv == 64'd0));
                            pend_next.kind = KIND_SCHED;
                            pend_next.last = 1'b1;
                            if (!rej)
                            begin
                                cmd.kind     = CMD_LOAD;
                                cmd.deadline = dl;
                                cmd.period   = pv;
                                cmd.repeats  = (s_tuser == OP_SCHED_PD);
                                cmd.handle   = hctr_reg;
                                cmd.order    = octr_reg;
                                cmd.fires    = 32'd0;
                                sel[free_idx] = 1'b1;
                                pend_next.handle   = hctr_reg;
                                pend_next.deadline = dl;
                                hctr_next = hinc;
                                octr_next = octr_reg + 64'd1;
                            end
                            pend_v_next = 1'b1;
                            state_next  = ST_FLUSH;
                        end
                        OP_CANCEL:
                        begin
                            if (match_hit)
                            begin
                                cmd.kind       = CMD_DROP;
                                sel[match_idx] = 1'b1;
                            end
                            pend_next.kind   = KIND_CANCEL;
                            pend_next.handle = hin;
                            pend_next.found  = match_hit;
                            pend_next.last   = 1'b1;
                            pend_v_next      = 1'b1;
                            state_next       = ST_FLUSH;
                        end
                        OP_PAUSE:
                        begin
                            paused_next = pflag;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != CW'(EVENT_SLOTS))
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (!pend_v_reg || !out_v_reg)
                begin
                    hit = best.valid && (nfire_reg != NW'(MAX_FIRES_PER_TICK));
                    if (pend_v_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = !hit;
                        out_v_next    = 1'b1;
                        pend_v_next   = 1'b0;
                    end
                    if (hit)
                    begin
                        pend_next.kind     = KIND_FIRED;
                        pend_next.handle   = bstat.handle;
                        pend_next.deadline = best.deadline;
                        pend_next.fired    = now_reg;
                        pend_next.late     = now_reg - best.deadline;
                        pend_next.count    = cnt1;
                        pend_next.found    = 1'b0;
                        pend_next.last     = 1'b0;
                        pend_v_next        = 1'b1;
                        sel[best_idx]      = 1'b1;
                        if (bstat.repeats)
                        begin
                            cmd.kind     = CMD_RESCHED;
                            cmd.deadline = sat_add(best.deadline, bstat.period);
                            cmd.order    = octr_reg;
                            cmd.fires    = cnt1;
                            octr_next    = octr_reg + 64'd1;
                        end
                        else
                        begin
                            cmd.kind = CMD_DROP;
                        end
                        nfire_next = nfire_reg + NW'(1);
                        cnt_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!out_v_reg)
                begin
                    out_next    = pend_reg;
                    out_v_next  = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            now_reg    <= '0;
            paused_reg <= 1'b0;
            hctr_reg   <= 32'd1;
            octr_reg   <= 64'd1;
            cnt_reg    <= '0;
            nfire_reg  <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            now_reg    <= now_next;
            paused_reg <= paused_next;
            hctr_reg   <= hctr_next;
            octr_reg   <= octr_next;
            cnt_reg    <= cnt_next;
            nfire_reg  <= nfire_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.found, out_reg.count, out_reg.late, out_reg.fired,
                       out_reg.deadline, out_reg.handle};

endmodule

// ----- hdl/tsch_cell.sv -----
`timescale 1ns / 1ps
module tsch_cell
    import tsch_pkg::*;
#(
    parameter int IW  = 4,
    parameter int IDX = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sel,
    input  cell_cmd_t       cmd,
    input  logic [63:0]     now,
    input  cand_t           cand_in,
    input  logic [IW-1:0]   idx_in,
    output cand_t           cand_out,
    output logic [IW-1:0]   idx_out,
    output cell_stat_t      stat
);

    logic        valid_reg;
    logic [63:0] deadline_reg;
    logic [63:0] period_reg;
    logic        repeats_reg;
    logic [31:0] handle_reg;
    logic [63:0] order_reg;
    logic [31:0] fires_reg;
    logic        cand_valid_reg;
    logic [63:0] cand_deadline_reg;
    logic [63:0] cand_order_reg;
    logic [IW-1:0] idx_reg;
    logic        due;
    logic        better;

    assign due    = valid_reg && (deadline_reg <= now);
    assign better = due && (!cand_in.valid || (deadline_reg < cand_in.deadline) ||
                    ((deadline_reg == cand_in.deadline) && (order_reg < cand_in.order)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            if (sel)
            begin
                case (cmd.kind)
                    CMD_LOAD:    valid_reg <= 1'b1;
                    CMD_DROP:    valid_reg <= 1'b0;
                    default:     valid_reg <= valid_reg;
                endcase
            end
            cand_valid_reg <= better ? 1'b1 : cand_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            case (cmd.kind)
                CMD_LOAD:
                begin
                    deadline_reg <= cmd.deadline;
                    period_reg   <= cmd.period;
                    repeats_reg  <= cmd.repeats;
                    handle_reg   <= cmd.handle;
                    order_reg    <= cmd.order;
                    fires_reg    <= cmd.fires;
                end
                CMD_RESCHED:
                begin
                    deadline_reg <= cmd.deadline;
                    order_reg    <= cmd.order;
                    fires_reg    <= cmd.fires;
                end
                default:
                begin
                end
            endcase
        end
        cand_deadline_reg <= better ? deadline_reg : cand_in.deadline;
        cand_order_reg    <= better ? order_reg : cand_in.order;
        idx_reg           <= better ? IW'(IDX) : idx_in;
    end

    assign cand_out.valid    = cand_valid_reg;
    assign cand_out.deadline = cand_deadline_reg;
    assign cand_out.order    = cand_order_reg;
    assign idx_out      = idx_reg;
    assign stat.valid   = valid_reg;
    assign stat.repeats = repeats_reg;
    assign stat.handle  = handle_reg;
    assign stat.fires   = fires_reg;
    assign stat.period  = period_reg;

endmodule
